// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file fmbq_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fmbq_pkg.sv =====
`default_nettype none

package fmbq_pkg;

    // Operation codes carried in the low bits of the input word
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_MID   = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_MID    = 3'd4,
        OP_POP_BACK   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int IN_RAW_W  = OP_W + WORD_W;
    localparam int OUT_RAW_W = STATUS_W + WORD_W + COUNT_W;
    localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // Shift command for the row of cells
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/fmbq_cells.sv =====
`default_nettype none

module fmbq_cells #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  fmbq_pkg::t_cell_cmd           i_cmd,
    input  logic [$clog2(DEPTH)-1:0]      i_pos,
    input  logic [fmbq_pkg::WORD_W-1:0]   i_word,
    output logic [fmbq_pkg::WORD_W-1:0]   o_rd_word
);
    import fmbq_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic [WORD_W-1:0] r_cell [DEPTH];

    assign o_rd_word = r_cell[i_pos];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] w_prev;
        logic [WORD_W-1:0] w_next;
        logic              w_eq;
        logic              w_gt;

        if (g == 0) begin : g_first
            assign w_prev = r_cell[g];
        end else begin : g_mid_prev
            assign w_prev = r_cell[g-1];
        end

        // last cell holds on a removal; it lies beyond the occupancy afterwards
        if (g == DEPTH - 1) begin : g_last
            assign w_next = r_cell[g];
        end else begin : g_mid_next
            assign w_next = r_cell[g+1];
        end

        assign w_eq = (PW'(g) == i_pos);
        assign w_gt = (PW'(g) >  i_pos);

        always_ff @(posedge i_clk) begin
            if (i_cmd.ins) begin
                if (w_eq) begin
                    r_cell[g] <= i_word;
                end else if (w_gt) begin
                    r_cell[g] <= w_prev;
                end
            end else if (i_cmd.rem && (w_eq || w_gt)) begin
                r_cell[g] <= w_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/front_middle_back_queue_core.sv =====
// Channel  | Dir | Word layout (bit 0 upwards)
// s_axis   | in  | operation[2:0], value[34:3], zero pad [39:35]
// m_axis   | out | status[1:0], popped_value[33:2], entry_count[38:34], zero pad [39]
//
// One word per clock in and out when neither side stalls; a word passes the input
// register, then the result register. The cell row shifts, and the pop read mux is
// read, as the word moves from the input register into the result register.
// i_rst_n is synchronous, active low: clears valids and the occupancy count. Cell
// contents are left as they are and are only read below the occupancy.
// A stall on m_axis holds the result register and the input register; s_axis_tready
// drops once the input register is full and cannot drain.
`default_nettype none

module front_middle_back_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // operation[2:0], value[34:3], pad
    input  logic [fmbq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status[1:0], popped_value[33:2], entry_count[38:34], pad
    output logic [fmbq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import fmbq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);

    // input register
    logic              r_in_vld;
    logic [OP_W-1:0]   r_in_op;
    logic [WORD_W-1:0] r_in_word;

    // occupancy
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    // result register
    logic              r_out_vld;
    t_status           r_out_status;
    logic [WORD_W-1:0] r_out_popped;
    logic [COUNT_W-1:0] r_out_count;

    logic              w_exec;
    logic              w_full;
    logic              w_empty;
    logic [CW-1:0]     w_cnt_m1;
    logic [PW-1:0]     w_pos;
    logic              w_is_push;
    logic              w_is_pop;
    t_status           w_status;
    t_cell_cmd         w_cmd;
    logic [WORD_W-1:0] w_rd_word;

    // advance when the result register is free or being drained this cycle
    assign w_exec        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_exec;

    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_cnt_m1 = r_count - CW'(1);

    // pick the insert or remove position from the operation and the count
    always_comb begin
        w_pos     = '0;
        w_is_push = 1'b0;
        w_is_pop  = 1'b0;
        case (r_in_op)
            OP_PUSH_FRONT: begin
                w_is_push = 1'b1;
            end
            OP_PUSH_MID: begin
                w_is_push = 1'b1;
                w_pos     = PW'(r_count >> 1);
            end
            OP_PUSH_BACK: begin
                w_is_push = 1'b1;
                w_pos     = PW'(r_count);
            end
            OP_POP_FRONT: begin
                w_is_pop  = 1'b1;
            end
            OP_POP_MID: begin
                w_is_pop  = 1'b1;
                w_pos     = PW'(w_cnt_m1 >> 1);
            end
            OP_POP_BACK: begin
                w_is_pop  = 1'b1;
                w_pos     = PW'(w_cnt_m1);
            end
            default: begin
                // unused codes: no operation, count reported unchanged
                w_pos     = '0;
            end
        endcase
    end

    always_comb begin
        w_cmd.ins = w_exec && w_is_push && !w_full;
        w_cmd.rem = w_exec && w_is_pop && !w_empty;
        if (w_is_push && w_full) begin
            w_status = ST_FULL;
        end else if (w_is_pop && w_empty) begin
            w_status = ST_EMPTY;
        end else begin
            w_status = ST_DONE;
        end
        if (w_cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.rem) begin
            n_count = w_cnt_m1;
        end else begin
            n_count = r_count;
        end
    end

    fmbq_cells #(
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_pos     (w_pos),
        .i_word    (r_in_word),
        .o_rd_word (w_rd_word)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_count   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (w_exec) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tdata[OP_W-1:0];
            r_in_word <= s_axis_tdata[OP_W +: WORD_W];
        end
        if (w_exec) begin
            r_out_status <= w_status;
            r_out_popped <= w_cmd.rem ? w_rd_word : '0;
            r_out_count  <= COUNT_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_count, r_out_popped, r_out_status});

endmodule

`default_nettype wire

// ===== rtl/fmbq_chk.sv =====
`default_nettype none

module fmbq_chk #(
    parameter int DEPTH = 16
) (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               s_axis_tvalid,
    input wire                               s_axis_tready,
    input wire [fmbq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [fmbq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import fmbq_pkg::*;
    `include "assert_macros.svh"

    logic [STATUS_W-1:0] w_status;
    logic [WORD_W-1:0]   w_popped;
    logic [COUNT_W-1:0]  w_count;
    logic                w_in_seen;

    assign w_status  = m_axis_tdata[STATUS_W-1:0];
    assign w_popped  = m_axis_tdata[STATUS_W +: WORD_W];
    assign w_count   = m_axis_tdata[STATUS_W + WORD_W +: COUNT_W];
    assign w_in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '1);

    // a stalled result word holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed under stall")
    // reset empties the output side
    `ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")
    // refused or empty results carry no popped word
    `ASSERT_CLK(a_no_pop_word, i_clk, i_rst_n, m_axis_tvalid && (w_status != ST_DONE) |-> (w_popped == '0), "popped word on a refused operation")
    // an empty pop reports zero entries
    `ASSERT_CLK(a_empty_cnt, i_clk, i_rst_n, m_axis_tvalid && (w_status == ST_EMPTY) |-> (w_count == '0), "empty status with entries held")
    // a refused push reports a full store when DEPTH < 32, unless an input word other than all ones is accepted
    `ASSERT_CLK(a_full_cnt, i_clk, i_rst_n, m_axis_tvalid && (w_status == ST_FULL) && (DEPTH < 32) |-> (w_count == COUNT_W'(DEPTH)) || w_in_seen, "full status below depth")

endmodule

bind front_middle_back_queue_core fmbq_chk #(.DEPTH(DEPTH)) u_fmbq_chk (.*);

`default_nettype wire
